// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with remove.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int REQ_W   = 3;
   localparam int STAT_W  = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_POP_BACK   = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_REMOVE     = 3'd4
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD,
      ST_CMP,
      ST_SH_RD,
      ST_SH_WR,
      ST_DONE
   } state_type;

   // slot storage access from the sequencer
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]         rd_addr;
   } mem_req_type;

   // finished transaction toward the response register
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } done_type;

endpackage

// ----- rtl/bdq_req_if.sv -----
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdq_req_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

// ----- rtl/bdq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: entry count and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
   import bdq_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] entry_count;
   logic [STAT_W-1:0]  status;

   modport source (output valid, output entry_count, output status, input ready);
   modport sink   (input valid, input entry_count, input status, output ready);
endinterface

// ----- rtl/bdq_store.sv -----
// ----------------------------------------------------------------------------
// bdq_store
// Ring slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bdq_store (
   input  logic                              clock,
   input  bdq_pkg::mem_req_type              mem_req,
   output logic signed [bdq_pkg::DATA_W-1:0] rd_data
);
   import bdq_pkg::*;

   logic signed [DATA_W-1:0] slot_mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write one slot, read one slot
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= slot_mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer with one shared slot-address adder and one value comparator.
// Handles pushes and pops in one step, walks the ring for remove.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bdq_pkg::REQ_W-1:0]         req_type,
   input  logic signed [bdq_pkg::DATA_W-1:0] item_value,
   input  logic                              rsp_free,
   output bdq_pkg::done_type                 done,
   output bdq_pkg::mem_req_type              mem_req,
   input  logic signed [bdq_pkg::DATA_W-1:0] rd_data
);
   import bdq_pkg::*;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   req_code_type             op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   status_type               status_ff, status_in;

   logic [IDX_W-1:0]   offset;
   logic [IDX_W-1:0]   slot_addr;
   logic [COUNT_W-1:0] pos_ext;
   logic               is_full;
   logic               is_empty;
   logic               hit;

   // shared unit: physical slot = head + offset, and the value compare
   assign slot_addr = head_ff + offset;
   assign hit       = (rd_data == val_ff);
   assign pos_ext   = {1'b0, pos_ff};
   assign is_full   = (count_ff == COUNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      op_ff     <= op_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

   // next state and outputs
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      op_in           = op_ff;
      val_in          = val_ff;
      status_in       = status_ff;
      offset          = pos_ff;
      req_ready       = 1'b0;
      done.valid      = 1'b0;
      done.count      = count_ff;
      done.status     = status_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = slot_addr;
      mem_req.wr_data = val_ff;
      mem_req.rd_addr = slot_addr;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_code_type'(req_type);
               val_in   = item_value;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in = STAT_OK;
            state_in  = ST_DONE;
            case (op_ff)
               REQ_PUSH_BACK: begin
                  offset = count_ff[IDX_W-1:0];
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
               REQ_PUSH_FRONT: begin
                  offset = '1;
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     head_in       = slot_addr;
                     count_in      = count_ff + 1'b1;
                  end
               end
               REQ_POP_BACK: begin
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
               REQ_POP_FRONT: begin
                  offset = IDX_W'(1);
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     head_in  = slot_addr;
                     count_in = count_ff - 1'b1;
                  end
               end
               REQ_REMOVE: begin
                  if (is_empty) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     pos_in   = '0;
                     state_in = ST_RD;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end

         // fetch the entry at the search position
         ST_RD: begin
            offset   = pos_ff;
            state_in = ST_CMP;
         end

         // compare, then close the gap, advance to the next entry, or finish
         ST_CMP: begin
            if (hit) begin
               if ((pos_ext + 1'b1) < count_ff) begin
                  state_in = ST_SH_RD;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_DONE;
               end
            end else if ((pos_ext + 1'b1) == count_ff) begin
               status_in = STAT_NOT_FOUND;
               state_in  = ST_DONE;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_RD;
            end
         end

         // read the entry behind the gap
         ST_SH_RD: begin
            offset   = pos_ff + 1'b1;
            state_in = ST_SH_WR;
         end

         // move it forward one place
         ST_SH_WR: begin
            offset          = pos_ff;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data;
            pos_in          = pos_ff + 1'b1;
            if ((pos_ext + COUNT_W'(2)) < count_ff) begin
               state_in = ST_SH_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end

         // hand the result over once the response register is free
         ST_DONE: begin
            if (rsp_free) begin
               done.valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ----- rtl/bounded_deque_with_remove.sv -----
// Push, pop and unused codes pass through the execute and done states before
// the response is raised, and a new request is taken only back in idle.
// Remove reads and compares each searched entry in turn, then reads and
// rewrites each entry moved up; the walk is bound by the single slot read port.
// A response waiting in the output register does not block the next request.
// Reset empties the deque.
// ----------------------------------------------------------------------------
// bounded_deque_with_remove
// Bounded double-ended queue of signed 32-bit values with remove-by-value.
// ----------------------------------------------------------------------------
module bounded_deque_with_remove (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);
   import bdq_pkg::*;

   mem_req_type              mem_req;
   done_type                 done;
   logic signed [DATA_W-1:0] rd_data;
   logic                     rsp_free;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   status_type         rsp_status_ff;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_type   (req_chan.req_type),
      .item_value (req_chan.item_value),
      .rsp_free   (rsp_free),
      .done       (done),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   bdq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // hold the response until the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_count_ff  <= done.count;
         rsp_status_ff <= done.status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;
endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque with remove. A fixed list of
// corner-case requests runs first: empty pops, full pushes, extreme values,
// duplicate removes and unused codes. Weighted random traffic follows, which
// swings the deque between full and empty. Every response is compared with a
// hand-written expectation for typed rows, else with a queue-based prediction
// of the deque's contents, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bdq_pkg::*;

   // Codes the block must ignore
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI  = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   localparam int          NUM_DIRECTED = 18;
   localparam int          RANDOM_ITEMS = 2000;
   localparam int          PHASE_LEN    = 40;
   localparam int          DRAIN_CYCLES = 4 * DEPTH + 8;
   localparam int unsigned CYCLE_LIMIT  = 1_200_000;

   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_mode_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      status_type         status;
   } deque_resp_type;

   typedef struct {
      logic [REQ_W-1:0]         code;
      logic signed [DATA_W-1:0] value;
      int                       repeat_n;
      bit                       typed;
      logic [COUNT_W-1:0]       count;
      status_type               status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdq_req_if req_bus ();
   bdq_rsp_if rsp_bus ();

   bounded_deque_with_remove uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predicted deque contents, front at index 0
   logic signed [DATA_W-1:0] deque_contents [$];
   deque_resp_type           pending_results [$];

   int error_count = 0;
   int requests_sent = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   bit steady_flow = 1'b0;

   // Directed corner cases; typed rows carry a hand-written response
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{REQ_POP_BACK,   0,       1, 1'b1, 0,  STAT_EMPTY},
      '{REQ_POP_FRONT,  0,       1, 1'b1, 0,  STAT_EMPTY},
      '{REQ_REMOVE,     0,       1, 1'b1, 0,  STAT_NOT_FOUND},
      '{REQ_UNUSED_LO,  0,       1, 1'b1, 0,  STAT_OK},
      '{REQ_PUSH_BACK,  VAL_MAX, 1, 1'b1, 1,  STAT_OK},
      '{REQ_POP_FRONT,  0,       1, 1'b1, 0,  STAT_OK},
      '{REQ_PUSH_FRONT, VAL_MIN, 1, 1'b1, 1,  STAT_OK},
      '{REQ_PUSH_BACK,  VAL_MAX, 1, 1'b1, 2,  STAT_OK},
      '{REQ_REMOVE,     VAL_MAX, 1, 1'b1, 1,  STAT_OK},
      '{REQ_POP_BACK,   0,       1, 1'b1, 0,  STAT_OK},
      '{REQ_PUSH_BACK,  0,       8, 1'b0, 0,  STAT_OK},
      '{REQ_PUSH_FRONT, -1,      8, 1'b0, 0,  STAT_OK},
      '{REQ_PUSH_BACK,  5,       1, 1'b1, 16, STAT_FULL},
      '{REQ_PUSH_FRONT, 5,       1, 1'b1, 16, STAT_FULL},
      '{REQ_UNUSED_HI,  VAL_MIN, 1, 1'b1, 16, STAT_OK},
      '{REQ_REMOVE,     0,       1, 1'b1, 15, STAT_OK},
      '{REQ_REMOVE,     12345,   1, 1'b1, 15, STAT_NOT_FOUND},
      '{REQ_UNUSED_MID, VAL_MAX, 1, 1'b1, 15, STAT_OK}
   };

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one request to the predicted deque and return its response
   function automatic deque_resp_type predict_deque(input logic [REQ_W-1:0] code,
                                                    input logic signed [DATA_W-1:0] value);
      deque_resp_type resp;
      int             hit;
      resp.status = STAT_OK;
      hit = -1;
      case (code)
         REQ_PUSH_BACK: begin
            if (deque_contents.size() >= DEPTH) resp.status = STAT_FULL;
            else deque_contents.insert(deque_contents.size(), value);
         end
         REQ_PUSH_FRONT: begin
            if (deque_contents.size() >= DEPTH) resp.status = STAT_FULL;
            else deque_contents.insert(0, value);
         end
         REQ_POP_BACK: begin
            if (deque_contents.size() == 0) resp.status = STAT_EMPTY;
            else deque_contents.delete(deque_contents.size() - 1);
         end
         REQ_POP_FRONT: begin
            if (deque_contents.size() == 0) resp.status = STAT_EMPTY;
            else deque_contents.delete(0);
         end
         REQ_REMOVE: begin
            // only the match nearest the front goes
            for (int i = 0; i < deque_contents.size(); i++) begin
               if (hit < 0 && deque_contents[i] == value) hit = i;
            end
            if (hit < 0) resp.status = STAT_NOT_FOUND;
            else deque_contents.delete(hit);
         end
         default: ;
      endcase
      resp.count = COUNT_W'(deque_contents.size());
      return resp;
   endfunction

   // Mostly short gaps, a few long ones, none while traffic is steady
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Weight operations by phase so the deque swings between full and empty
   function automatic logic [REQ_W-1:0] pick_req_code(input mix_mode_type mode);
      int unsigned roll;
      int unsigned push_pct;
      int unsigned pop_pct;
      roll = $urandom_range(0, 99);
      case (mode)
         MIX_FILL:  begin push_pct = 65; pop_pct = 20; end
         MIX_DRAIN: begin push_pct = 20; pop_pct = 62; end
         default:   begin push_pct = 40; pop_pct = 35; end
      endcase
      if (roll < 3) return REQ_W'(REQ_UNUSED_LO + $urandom_range(0, 2));
      if (roll < 3 + push_pct)
         return ($urandom_range(0, 1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      if (roll < 3 + push_pct + pop_pct)
         return ($urandom_range(0, 1) != 0) ? REQ_POP_FRONT : REQ_POP_BACK;
      return REQ_REMOVE;
   endfunction

   // Favor a small value pool and stored values so removes often hit
   function automatic logic signed [DATA_W-1:0] pick_value(input logic [REQ_W-1:0] code);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (code == REQ_REMOVE && roll < 70 && deque_contents.size() > 0)
         return deque_contents[$urandom_range(0, deque_contents.size() - 1)];
      if (roll < 50) return DATA_W'(int'($urandom_range(0, 7)) - 4);
      if (roll < 60) return (roll[0]) ? VAL_MAX : VAL_MIN;
      return $urandom();
   endfunction

   // Drive one transaction and record its response once accepted
   task automatic send_req(input logic [REQ_W-1:0]         code,
                           input logic signed [DATA_W-1:0] value,
                           input bit                       typed,
                           input logic [COUNT_W-1:0]       typed_count,
                           input status_type               typed_status);
      int unsigned    gap;
      deque_resp_type predicted;
      deque_resp_type queued;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= code;
      req_bus.item_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_deque(code, value);
      if (typed) begin
         queued.count  = typed_count;
         queued.status = typed_status;
      end else begin
         queued = predicted;
      end
      pending_results.insert(pending_results.size(), queued);
      requests_sent++;
   endtask

   // Compare one response with the oldest expectation
   task automatic check_response();
      deque_resp_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected response: entry_count=%0d status=%0d",
                rsp_bus.entry_count, rsp_bus.status);
         error_count++;
      end else begin
         want = pending_results[0];
         pending_results.delete(0);
         if (rsp_bus.entry_count !== want.count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.count, rsp_bus.entry_count);
            error_count++;
         end
         if (rsp_bus.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, rsp_bus.status);
            error_count++;
         end
      end
      if (!$isunknown(rsp_bus.status)) status_seen[rsp_bus.status]++;
   endtask

   // Response side: check on handshake, stall at random
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_response();
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Hard stop for a hung block
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus: reset, directed rows, random phases, then drain
   initial begin : stimulus
      mix_mode_type     mode;
      logic [REQ_W-1:0] code;
      mode = MIX_EVEN;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_PUSH_BACK;
      req_bus.item_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].repeat_n; k++) begin
            send_req(directed_rows[r].code, directed_rows[r].value, directed_rows[r].typed,
                     directed_rows[r].count, directed_rows[r].status);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            mode = mix_mode_type'($urandom_range(0, 2));
            steady_flow = ($urandom_range(0, 4) == 0);
         end
         code = pick_req_code(mode);
         send_req(code, pick_value(code), 1'b0, '0, STAT_OK);
      end

      // Drop valid and wait for the last responses
      req_bus.valid <= 1'b0;
      steady_flow = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests across fill, drain and mixed phases with random stalls.",
               requests_sent);
      $display("Responses seen: ok %0d, full %0d, empty %0d, not found %0d; errors %0d.",
               status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
               status_seen[STAT_NOT_FOUND], error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
